FILE: rtl/prot_pkg.sv
package prot_pkg;

	localparam int COORD_W    = 12;
	localparam int ANGLE_W    = 8;
	localparam int LIMIT_W    = 10;
	localparam int DIFF_W     = COORD_W + 1;
	localparam int FRAC_BITS  = 16;
	localparam int TRIG_W     = FRAC_BITS + 2;
	localparam int PROD_W     = TRIG_W + DIFF_W;
	localparam int SUM_W      = PROD_W + 1;
	localparam int SHIFT_W    = SUM_W - FRAC_BITS;
	localparam int FULL_W     = SHIFT_W + 1;

	localparam int TABLE_LEN   = 20;
	localparam int ANGLE_STEPS = 20;
	localparam int TAB_IDX_W   = $clog2(TABLE_LEN);

	localparam logic [LIMIT_W-1:0] MAX_X_RST = LIMIT_W'(320);
	localparam logic [LIMIT_W-1:0] MAX_Y_RST = LIMIT_W'(240);

	localparam int CFG_IDX_W = 2;
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MAX_X = 2'd0,
		CFG_MAX_Y = 2'd1
	} cfg_idx_t;

	localparam logic signed [TRIG_W-1:0] SIN_TAB [TABLE_LEN] = '{
		18'sd0,     18'sd1144,  18'sd2287,  18'sd3430,  18'sd4572,
		18'sd5712,  18'sd6850,  18'sd7987,  18'sd9121,  18'sd10252,
		18'sd11380, 18'sd12505, 18'sd13626, 18'sd14742, 18'sd15855,
		18'sd16962, 18'sd18064, 18'sd19161, 18'sd20252, 18'sd21336
	};

	localparam logic signed [TRIG_W-1:0] COS_TAB [TABLE_LEN] = '{
		18'sd65536, 18'sd65526, 18'sd65496, 18'sd65446, 18'sd65376,
		18'sd65287, 18'sd65177, 18'sd65048, 18'sd64898, 18'sd64729,
		18'sd64540, 18'sd64332, 18'sd64104, 18'sd63856, 18'sd63589,
		18'sd63303, 18'sd62997, 18'sd62672, 18'sd62328, 18'sd61966
	};

	typedef struct packed {
		logic signed [DIFF_W-1:0]  dx;
		logic signed [DIFF_W-1:0]  dy;
		logic signed [TRIG_W-1:0]  sn;
		logic signed [TRIG_W-1:0]  cs;
		logic signed [COORD_W-1:0] cx;
		logic signed [COORD_W-1:0] cy;
	} prot_s1_t;

endpackage

FILE: rtl/point_rotate_about_center.sv
// a start beat goes via the input and result registers to rot_x/rot_y with done
// throughput: one beat per cycle, busy never rises
// sine and cosine lookup and offsets sit before the input register, the four
// multiplies, shift and clamp before the result register
// arst_n clears the stage valids and sets max_x to 320 and max_y to 240
// done is a one-cycle strobe, the receiver cannot stall
module point_rotate_about_center
	import prot_pkg::*;
#(
	parameter int ANGLE_STEPS = prot_pkg::ANGLE_STEPS
)
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic signed [COORD_W-1:0] point_x,
	input  logic signed [COORD_W-1:0] point_y,
	input  logic signed [COORD_W-1:0] center_x,
	input  logic signed [COORD_W-1:0] center_y,
	input  logic signed [ANGLE_W-1:0] angle,
	output logic                      done,
	output logic [LIMIT_W-1:0]        rot_x,
	output logic [LIMIT_W-1:0]        rot_y,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [CFG_IDX_W-1:0]      cfg_index,
	input  logic [LIMIT_W-1:0]        cfg_data
);

	logic               vld_s1;
	prot_s1_t           data_s1;
	logic [LIMIT_W-1:0] max_x_q, max_y_q;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_x_q <= MAX_X_RST;
			max_y_q <= MAX_Y_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_MAX_X: max_x_q <= cfg_data;
				CFG_MAX_Y: max_y_q <= cfg_data;
				default: ;
			endcase
		end
	end

	prot_input #(
		.ANGLE_STEPS (ANGLE_STEPS)
	) u_input (
		.clk      (clk),
		.arst_n   (arst_n),
		.take     (start && !busy),
		.point_x  (point_x),
		.point_y  (point_y),
		.center_x (center_x),
		.center_y (center_y),
		.angle    (angle),
		.vld_s1   (vld_s1),
		.data_s1  (data_s1)
	);

	prot_rotate u_rotate (
		.clk     (clk),
		.arst_n  (arst_n),
		.vld_s1  (vld_s1),
		.data_s1 (data_s1),
		.max_x   (max_x_q),
		.max_y   (max_y_q),
		.done    (done),
		.rot_x   (rot_x),
		.rot_y   (rot_y)
	);

endmodule

FILE: rtl/prot_input.sv
module prot_input
	import prot_pkg::*;
#(
	parameter int ANGLE_STEPS = prot_pkg::ANGLE_STEPS
)
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      take,
	input  logic signed [COORD_W-1:0] point_x,
	input  logic signed [COORD_W-1:0] point_y,
	input  logic signed [COORD_W-1:0] center_x,
	input  logic signed [COORD_W-1:0] center_y,
	input  logic signed [ANGLE_W-1:0] angle,
	output logic                      vld_s1,
	output prot_s1_t                  data_s1
);

	localparam int ANGLE_LIM = (ANGLE_STEPS < TABLE_LEN) ? ANGLE_STEPS : TABLE_LEN;

	logic                     ang_ok;
	logic [TAB_IDX_W-1:0]     tab_idx;
	prot_s1_t                 data_d;

	// negative angles and those past the table give zero sine and cosine
	assign ang_ok  = !angle[ANGLE_W-1] &&
		(angle[ANGLE_W-2:0] < (ANGLE_W-1)'(ANGLE_LIM));
	assign tab_idx = angle[TAB_IDX_W-1:0];

	always_comb begin
		data_d.dx = DIFF_W'(point_x) - DIFF_W'(center_x);
		data_d.dy = DIFF_W'(point_y) - DIFF_W'(center_y);
		data_d.sn = ang_ok ? SIN_TAB[tab_idx] : '0;
		data_d.cs = ang_ok ? COS_TAB[tab_idx] : '0;
		data_d.cx = center_x;
		data_d.cy = center_y;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= take;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			data_s1 <= data_d;
		end
	end

endmodule

FILE: rtl/prot_rotate.sv
module prot_rotate
	import prot_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               vld_s1,
	input  prot_s1_t           data_s1,
	input  logic [LIMIT_W-1:0] max_x,
	input  logic [LIMIT_W-1:0] max_y,
	output logic               done,
	output logic [LIMIT_W-1:0] rot_x,
	output logic [LIMIT_W-1:0] rot_y
);

	function automatic logic [LIMIT_W-1:0] clamp(input logic signed [FULL_W-1:0] v,
		input logic [LIMIT_W-1:0] lim);
		logic [LIMIT_W-1:0] r;
		if (v[FULL_W-1]) begin
			r = '0;
		end else if (v > $signed({{(FULL_W-LIMIT_W){1'b0}}, lim})) begin
			r = lim;
		end else begin
			r = v[LIMIT_W-1:0];
		end
		return r;
	endfunction

	logic signed [PROD_W-1:0]  p_cdx, p_sdy, p_sdx, p_cdy;
	logic signed [SUM_W-1:0]   sum_x, sum_y;
	logic signed [SHIFT_W-1:0] sh_x, sh_y;
	logic signed [FULL_W-1:0]  full_x, full_y;
	logic                      done_s2;
	logic [LIMIT_W-1:0]        rot_x_s2, rot_y_s2;

	assign p_cdx  = PROD_W'(data_s1.cs) * PROD_W'(data_s1.dx);
	assign p_sdy  = PROD_W'(data_s1.sn) * PROD_W'(data_s1.dy);
	assign p_sdx  = PROD_W'(data_s1.sn) * PROD_W'(data_s1.dx);
	assign p_cdy  = PROD_W'(data_s1.cs) * PROD_W'(data_s1.dy);
	assign sum_x  = SUM_W'(p_cdx) - SUM_W'(p_sdy);
	assign sum_y  = SUM_W'(p_sdx) + SUM_W'(p_cdy);
	// floor shift is the upper bits of the two's complement sum
	assign sh_x   = sum_x[SUM_W-1:FRAC_BITS];
	assign sh_y   = sum_y[SUM_W-1:FRAC_BITS];
	assign full_x = FULL_W'(sh_x) + FULL_W'(data_s1.cx);
	assign full_y = FULL_W'(sh_y) + FULL_W'(data_s1.cy);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s2 <= 1'b0;
		end else begin
			done_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			rot_x_s2 <= clamp(full_x, max_x);
			rot_y_s2 <= clamp(full_y, max_y);
		end
	end

	assign done  = done_s2;
	assign rot_x = rot_x_s2;
	assign rot_y = rot_y_s2;

endmodule

FILE: rtl/prot_checker.sv
module prot_checker
	import prot_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic               done,
	input logic [LIMIT_W-1:0] rot_x,
	input logic               cfg_valid,
	input logic               cfg_ready,
	input logic [CFG_IDX_W-1:0] cfg_index,
	input logic [LIMIT_W-1:0] cfg_data
);

	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");

	a_beat_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##2 done)
		else $error("accepted beat gave no result");

	a_done_has_beat: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 2))
		else $error("result without accepted beat");

	// a zero limit on x forces rot_x to zero
	a_zero_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_valid && cfg_ready && cfg_index == CFG_MAX_X && cfg_data == '0)
		##1 (start && !busy) ##2 done |-> rot_x == '0)
		else $error("rot_x above zero limit");

endmodule

bind point_rotate_about_center prot_checker u_prot_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.done      (done),
	.rot_x     (rot_x),
	.cfg_valid (cfg_valid),
	.cfg_ready (cfg_ready),
	.cfg_index (cfg_index),
	.cfg_data  (cfg_data)
);
